FILE: src/lwbc_pkg.sv
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared widths, request kind codes and the command and status bundles
// passed between the cache directory controller and its datapath.
// ----------------------------------------------------------------------------
package lwbc_pkg;

  // field widths fixed by the interface
  localparam int KIND_W = 2;
  localparam int ADDR_W = 32;
  localparam int WAY_W  = 4;

  // request kind codes
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic accept;       // item taken, latch the request
    logic flush_start;  // item is a flush, rewind the walk
    logic lookup;       // compare tags and pick the target entry
    logic update;       // apply the access and send its result
    logic flush_step;   // visit one recency position
    logic flush_done;   // send the closing result, invalidate all
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_last;     // flush walk is at the most recent position
  } stat_t;

endpackage

FILE: src/lwbc_ctrl.sv
// ----------------------------------------------------------------------------
// lwbc_ctrl
// Sequencer for the cache directory: an access goes through a lookup and an
// update step, a flush walks every recency position and then closes.
// ----------------------------------------------------------------------------
module lwbc_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [lwbc_pkg::KIND_W-1:0]       in_kind,
  input  lwbc_pkg::stat_t                   stat,
  output logic                              busy,
  output lwbc_pkg::cmd_t                    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_RESP   = 3'd2;
  localparam logic [2:0] ST_FLUSH  = 3'd3;
  localparam logic [2:0] ST_FL_END = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       can_take;
  logic       accept;
  logic [2:0] entry_state;

  // a new item may come in during the last cycle of the previous one
  assign can_take = (state_r == ST_IDLE) || (state_r == ST_RESP) ||
                    (state_r == ST_FL_END);
  assign busy     = !can_take;
  assign accept   = start && can_take;

  // first state of an accepted item
  always_comb begin
    unique case (in_kind)
      lwbc_pkg::KIND_READ:  entry_state = ST_LOOKUP;
      lwbc_pkg::KIND_WRITE: entry_state = ST_LOOKUP;
      lwbc_pkg::KIND_FLUSH: entry_state = ST_FLUSH;
      lwbc_pkg::KIND_NONE:  entry_state = ST_IDLE;
      default:              entry_state = ST_IDLE;
    endcase
  end

  // next state
  always_comb begin
    unique case (state_r)
      ST_IDLE, ST_RESP, ST_FL_END: begin
        state_nxt = accept ? entry_state : ST_IDLE;
      end
      ST_LOOKUP: state_nxt = ST_RESP;
      ST_FLUSH:  state_nxt = stat.pos_last ? ST_FL_END : ST_FLUSH;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd.accept      = accept;
    cmd.flush_start = accept && (in_kind == lwbc_pkg::KIND_FLUSH);
    cmd.lookup      = (state_r == ST_LOOKUP);
    cmd.update      = (state_r == ST_RESP);
    cmd.flush_step  = (state_r == ST_FLUSH);
    cmd.flush_done  = (state_r == ST_FL_END);
  end

endmodule

FILE: src/lwbc_datapath.sv
// ----------------------------------------------------------------------------
// lwbc_datapath
// Tag store, valid and dirty bits and per-entry recency rank of the cache
// directory, with the parallel tag compare, the flush walk and the result
// registers.
// ----------------------------------------------------------------------------
module lwbc_datapath #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lwbc_pkg::cmd_t                    cmd,
  output lwbc_pkg::stat_t                   stat,
  input  logic [lwbc_pkg::KIND_W-1:0]       in_kind,
  input  logic [lwbc_pkg::ADDR_W-1:0]       in_block_addr,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [lwbc_pkg::WAY_W-1:0]        out_way,
  output logic                              out_fill_needed,
  output logic                              out_wb_valid,
  output logic [lwbc_pkg::ADDR_W-1:0]       out_wb_addr,
  output logic                              out_last
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int EXT_W = IDX_W + lwbc_pkg::WAY_W;

  // entry index to way field, zero extended or masked
  function automatic logic [lwbc_pkg::WAY_W-1:0] to_way(input logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(idx);
    return ext[lwbc_pkg::WAY_W-1:0];
  endfunction

  // request
  logic [lwbc_pkg::ADDR_W-1:0] req_addr_r;
  logic                        req_write_r;

  // directory state
  logic [lwbc_pkg::ADDR_W-1:0] tag_r [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]      valid_r;
  logic [NUM_ENTRIES-1:0]      dirty_r;
  logic [IDX_W-1:0]            rank_r [NUM_ENTRIES];

  // lookup result
  logic             lk_hit_r;
  logic [IDX_W-1:0] lk_idx_r;
  logic [IDX_W-1:0] lk_rank_r;

  // flush walk
  logic [IDX_W-1:0]            pos_r;
  logic                        pend_v_r;
  logic [IDX_W-1:0]            pend_way_r;
  logic [lwbc_pkg::ADDR_W-1:0] pend_addr_r;

  // result registers
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [lwbc_pkg::WAY_W-1:0]  out_way_r;
  logic                        out_fill_r;
  logic                        out_wbv_r;
  logic [lwbc_pkg::ADDR_W-1:0] out_wba_r;
  logic                        out_last_r;

  // combinational
  logic [NUM_ENTRIES-1:0]      hit_vec;
  logic [NUM_ENTRIES-1:0]      vic_vec;
  logic [NUM_ENTRIES-1:0]      fl_vec;
  logic [NUM_ENTRIES-1:0]      tgt_vec;
  logic [IDX_W-1:0]            tgt_idx;
  logic [IDX_W-1:0]            tgt_rank;
  logic [IDX_W-1:0]            fl_idx;
  logic                        fl_wb;
  logic [IDX_W-1:0]            rd_idx;
  logic [lwbc_pkg::ADDR_W-1:0] rd_tag;
  logic                        miss_wb;

  // per-entry tag match, least recent entry and flush position match
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == req_addr_r);
      vic_vec[i] = (rank_r[i] == '0);
      fl_vec[i]  = (rank_r[i] == pos_r);
    end
  end

  // encode the target entry and the flush entry
  always_comb begin
    tgt_vec  = (|hit_vec) ? hit_vec : vic_vec;
    tgt_idx  = '0;
    tgt_rank = '0;
    fl_idx   = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tgt_vec[i]) begin
        tgt_idx  = tgt_idx | IDX_W'(i);
        tgt_rank = tgt_rank | rank_r[i];
      end
      if (fl_vec[i]) begin
        fl_idx = fl_idx | IDX_W'(i);
      end
    end
    fl_wb = |(fl_vec & valid_r & dirty_r);
  end

  // single tag read port shared by the update and the flush walk
  assign rd_idx  = cmd.flush_step ? fl_idx : lk_idx_r;
  assign rd_tag  = tag_r[rd_idx];
  assign miss_wb = !lk_hit_r && valid_r[lk_idx_r] && dirty_r[lk_idx_r];

  assign stat.pos_last = (pos_r == IDX_W'(NUM_ENTRIES - 1));

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_addr_r  <= in_block_addr;
      req_write_r <= (in_kind == lwbc_pkg::KIND_WRITE);
    end
  end

  // lookup result latch
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      lk_hit_r  <= |hit_vec;
      lk_idx_r  <= tgt_idx;
      lk_rank_r <= tgt_rank;
    end
  end

  // tag install on a miss
  always_ff @(posedge clk) begin
    if (cmd.update && !lk_hit_r) begin
      tag_r[lk_idx_r] <= req_addr_r;
    end
  end

  // valid, dirty and recency update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        rank_r[i] <= IDX_W'(i);
      end
    end else begin
      priority if (cmd.update) begin
        valid_r[lk_idx_r] <= 1'b1;
        dirty_r[lk_idx_r] <= lk_hit_r ? (dirty_r[lk_idx_r] | req_write_r) : req_write_r;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (IDX_W'(i) == lk_idx_r) begin
            rank_r[i] <= IDX_W'(NUM_ENTRIES - 1);
          end else if (rank_r[i] > lk_rank_r) begin
            rank_r[i] <= rank_r[i] - 1'b1;
          end
        end
      end else if (cmd.flush_done) begin
        valid_r <= '0;
        dirty_r <= '0;
      end else begin
        valid_r <= valid_r;
      end
    end
  end

  // flush walk position and held writeback, sent once the next one is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      priority if (cmd.flush_start) begin
        pos_r    <= '0;
        pend_v_r <= 1'b0;
      end else if (cmd.flush_step) begin
        pos_r <= pos_r + 1'b1;
        if (fl_wb) begin
          pend_v_r <= 1'b1;
        end
      end else if (cmd.flush_done) begin
        pend_v_r <= 1'b0;
      end else begin
        pos_r <= pos_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_step && fl_wb) begin
      pend_way_r  <= fl_idx;
      pend_addr_r <= rd_tag;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update || cmd.flush_done || (cmd.flush_step && fl_wb && pend_v_r);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    priority if (cmd.update) begin
      out_hit_r  <= lk_hit_r;
      out_way_r  <= to_way(lk_idx_r);
      out_fill_r <= !lk_hit_r && !req_write_r;
      out_wbv_r  <= miss_wb;
      out_wba_r  <= miss_wb ? rd_tag : '0;
      out_last_r <= 1'b1;
    end else if (cmd.flush_step && fl_wb && pend_v_r) begin
      out_hit_r  <= 1'b0;
      out_way_r  <= to_way(pend_way_r);
      out_fill_r <= 1'b0;
      out_wbv_r  <= 1'b1;
      out_wba_r  <= pend_addr_r;
      out_last_r <= 1'b0;
    end else if (cmd.flush_done) begin
      out_hit_r  <= 1'b0;
      out_way_r  <= pend_v_r ? to_way(pend_way_r) : '0;
      out_fill_r <= 1'b0;
      out_wbv_r  <= pend_v_r;
      out_wba_r  <= pend_v_r ? pend_addr_r : '0;
      out_last_r <= 1'b1;
    end else begin
      out_last_r <= out_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_way         = out_way_r;
  assign out_fill_needed = out_fill_r;
  assign out_wb_valid    = out_wbv_r;
  assign out_wb_addr     = out_wba_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // a block address is held by at most one valid entry
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one entry matches the request address");

  // recency ranks stay a permutation: exactly one least recent entry
  a_one_lru: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(vic_vec))
    else $error("recency ranks lost their single least recent entry");

  // an access update always sends one final result
  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (out_valid_r && out_last_r))
    else $error("access update without a final result");

  // a closed flush leaves nothing valid or dirty
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_done |=> (valid_r == '0) && (dirty_r == '0))
    else $error("entries still valid after flush");
`endif

endmodule

FILE: src/lru_writeback_block_cache_directory.sv
// Access (read or write): tag compare, then recency update, then a registered
// result strobe; a new item can be taken during the recency update.
// Flush: one recency position per clock, one result per dirty entry, or a
// single closing result when nothing is dirty.
// The receiver cannot stall results. Reset (rst_n low, synchronous): entries
// invalid and clean, recency order by entry index, ready as soon as rst_n is high.
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_directory
// Directory of a fully associative write-back block cache with
// least-recently-used replacement and whole-cache flush.
// ----------------------------------------------------------------------------
module lru_writeback_block_cache_directory #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [lwbc_pkg::KIND_W-1:0]       in_kind,
  input  logic [lwbc_pkg::ADDR_W-1:0]       in_block_addr,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [lwbc_pkg::WAY_W-1:0]        out_way,
  output logic                              out_fill_needed,
  output logic                              out_wb_valid,
  output logic [lwbc_pkg::ADDR_W-1:0]       out_wb_addr,
  output logic                              out_last
);

  lwbc_pkg::cmd_t  cmd;
  lwbc_pkg::stat_t stat;

  // sequencer
  lwbc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // directory state and result registers
  lwbc_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_block_addr   (in_block_addr),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_way         (out_way),
    .out_fill_needed (out_fill_needed),
    .out_wb_valid    (out_wb_valid),
    .out_wb_addr     (out_wb_addr),
    .out_last        (out_last)
  );

endmodule
